### rtl/hsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman stream decoder package
// Shared constants, result codes and the control struct that runs between the
// decoder core and its result stage.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int NODE_SLOTS_DEF  = 512;
    localparam int STACK_DEPTH_DEF = 256;

    localparam int BUDGET_W    = 40;
    localparam int SYM_W       = 8;
    localparam int OUTCOME_W   = 2;
    localparam int BYTE_BITS   = 8;
    localparam int LETTER_BITS = 8;
    localparam int CNT_W       = 4;

    localparam logic [OUTCOME_W-1:0] OC_SYMBOL  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OC_END     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OC_CORRUPT = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]     symbol;
        logic [OUTCOME_W-1:0] outcome;
    } hsd_result_t;

    typedef struct packed {
        logic        push;
        logic        flush;
        hsd_result_t res;
    } hsd_rs_ctrl_t;

endpackage
`default_nettype wire

### rtl/hsd_result_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman stream decoder result stage
// Holds the newest result back until the next push or flush so that the last
// result of a byte can be tagged, and drives the registered output channel.
// ----------------------------------------------------------------------------
module hsd_result_stage
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hsd_pkg::hsd_rs_ctrl_t        ctrl,
    output logic                              room,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [hsd_pkg::SYM_W-1:0]         symbol,
    output logic [hsd_pkg::OUTCOME_W-1:0]     outcome,
    output logic                              last
);

    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    hsd_pkg::hsd_result_t  hold_reg;
    hsd_pkg::hsd_result_t  hold_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hsd_pkg::hsd_result_t  out_reg;
    hsd_pkg::hsd_result_t  out_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign room     = !hold_valid_reg || out_free;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        last_next       = last_reg;
        if (ctrl.push)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                last_next      = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = ctrl.res;
        end
        else if (ctrl.flush && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            last_next       = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_reg.symbol;
    assign outcome   = out_reg.outcome;
    assign last      = last_reg;

endmodule
`default_nettype wire

### rtl/huffman_stream_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman stream decoder
// Rebuilds a code tree from its pre-order serialization and decodes the data
// bits that follow it, one stream bit per cycle, under a total bit budget.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid / in_ready     stream_byte, first, final_req
//  output    out        out_valid / out_ready   symbol, outcome, last
//  config    in         cfg_write               cfg_data (bit budget)
//
// Each byte is taken in idle, its stream bits are shifted out of the shift
// register one by one, then the byte is closed and its last result tagged.
// A priming step reads the root from the child memories before the first data
// bit after the tree; a symbol that ends the budget is followed by an end step.
// Reset clears all control state; the node and stack memories are not cleared.
// The decoder stalls whole cycles while its result stage has no room.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_unit
#(
    parameter int NODE_SLOTS  = hsd_pkg::NODE_SLOTS_DEF,
    parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [hsd_pkg::BUDGET_W-1:0]    cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      stream_byte,
    input  wire logic                            first,
    input  wire logic                            final_req,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [hsd_pkg::SYM_W-1:0]            symbol,
    output logic [hsd_pkg::OUTCOME_W-1:0]        outcome,
    output logic                                 last
);

    localparam int IW     = $clog2(NODE_SLOTS);
    localparam int NCW    = $clog2(NODE_SLOTS + 1);
    localparam int SIW    = $clog2(STACK_DEPTH);
    localparam int LW     = $clog2(STACK_DEPTH + 1);
    localparam int SW     = hsd_pkg::SYM_W;
    localparam int LINK_W = 1 + SW + IW;
    localparam int BW     = hsd_pkg::BUDGET_W;
    localparam int CW     = hsd_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BIT   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [1:0] PH_TREE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]     state_reg,      state_next;
    logic [7:0]     byte_reg,       byte_next;
    logic [CW-1:0]  cnt_reg,        cnt_next;
    logic           final_reg,      final_next;
    logic [BW-1:0]  budget_reg;
    logic [BW-1:0]  rem_reg,        rem_next;
    logic [1:0]     phase_reg,      phase_next;
    logic [CW-1:0]  lbt_reg,        lbt_next;
    logic [SW-1:0]  letter_reg,     letter_next;
    logic [NCW-1:0] nodes_reg,      nodes_next;
    logic [LW-1:0]  level_reg,      level_next;
    logic [IW-1:0]  top_node_reg,   top_node_next;
    logic           top_second_reg, top_second_next;
    logic           root_leaf_reg,  root_leaf_next;
    logic [SW-1:0]  root_letter_reg, root_letter_next;
    logic [IW-1:0]  walk_reg,       walk_next;
    logic           prime_reg,      prime_next;
    logic           fin_reg,        fin_next;

    logic [LINK_W-1:0] one_mem  [NODE_SLOTS];
    logic [LINK_W-1:0] zero_mem [NODE_SLOTS];
    logic [IW-1:0]     stk_mem  [STACK_DEPTH];
    logic [LINK_W-1:0] one_rd_reg;
    logic [LINK_W-1:0] zero_rd_reg;
    logic [IW-1:0]     below_rd_reg;

    logic              one_we;
    logic              zero_we;
    logic [LINK_W-1:0] link_wdata;
    logic              stk_we;
    logic [LW-1:0]     lvl_m1;
    logic [LW-1:0]     lvl_m2;
    logic [SIW-1:0]    stk_addr_w;
    logic [SIW-1:0]    stk_addr_r;

    logic              bit_b;
    logic              rem_one;
    logic              bad;
    logic              tree_done;
    logic              emit;
    logic [SW-1:0]     emit_sym;
    logic [SW-1:0]     letter_new;
    logic [IW-1:0]     new_idx;
    logic [LINK_W-1:0] link;

    hsd_pkg::hsd_rs_ctrl_t rs_ctrl;
    logic                  rs_room;

    assign lvl_m1     = level_reg - LW'(1);
    assign lvl_m2     = level_reg - LW'(2);
    assign stk_addr_w = lvl_m1[SIW-1:0];
    assign stk_addr_r = lvl_m2[SIW-1:0];
    assign bit_b      = byte_reg[7];
    assign rem_one    = (rem_reg == BW'(1));
    assign letter_new = {letter_reg[SW-2:0], bit_b};
    assign new_idx    = nodes_reg[IW-1:0];
    assign link       = bit_b ? one_rd_reg : zero_rd_reg;
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        byte_next        = byte_reg;
        cnt_next         = cnt_reg;
        final_next       = final_reg;
        rem_next         = rem_reg;
        phase_next       = phase_reg;
        lbt_next         = lbt_reg;
        letter_next      = letter_reg;
        nodes_next       = nodes_reg;
        level_next       = level_reg;
        top_node_next    = top_node_reg;
        top_second_next  = top_second_reg;
        root_leaf_next   = root_leaf_reg;
        root_letter_next = root_letter_reg;
        walk_next        = walk_reg;
        prime_next       = prime_reg;
        fin_next         = fin_reg;
        one_we           = 1'b0;
        zero_we          = 1'b0;
        link_wdata       = {1'b0, {SW{1'b0}}, new_idx};
        stk_we           = 1'b0;
        bad              = 1'b0;
        tree_done        = 1'b0;
        emit             = 1'b0;
        emit_sym         = '0;
        rs_ctrl          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = stream_byte;
                    cnt_next   = CW'(hsd_pkg::BYTE_BITS);
                    final_next = final_req;
                    state_next = ST_BIT;
                    if (first)
                    begin
                        rem_next   = budget_reg;
                        phase_next = PH_TREE;
                        lbt_next   = '0;
                        nodes_next = '0;
                        level_next = '0;
                        walk_next  = '0;
                        prime_next = 1'b0;
                        fin_next   = 1'b0;
                    end
                end
            end
            ST_BIT:
            begin
                if (rs_room)
                begin
                    if (fin_reg)
                    begin
                        fin_next           = 1'b0;
                        phase_next         = PH_DONE;
                        rs_ctrl.push       = 1'b1;
                        rs_ctrl.res.outcome = hsd_pkg::OC_END;
                    end
                    else if (prime_reg)
                    begin
                        prime_next = 1'b0;
                    end
                    else if (cnt_reg == '0 || phase_reg == PH_DONE)
                    begin
                        state_next = ST_FLUSH;
                        if (final_reg && phase_reg != PH_DONE)
                        begin
                            bad = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_next = {byte_reg[6:0], 1'b0};
                        cnt_next  = cnt_reg - CW'(1);
                        if (rem_reg == '0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            rem_next = rem_reg - BW'(1);
                            if (phase_reg == PH_TREE)
                            begin
                                if (lbt_reg == '0 && !bit_b)
                                begin
                                    lbt_next    = CW'(1);
                                    letter_next = '0;
                                end
                                else if (lbt_reg == '0)
                                begin
                                    if (nodes_reg == NCW'(NODE_SLOTS))
                                    begin
                                        bad = 1'b1;
                                    end
                                    else
                                    begin
                                        nodes_next = nodes_reg + NCW'(1);
                                        link_wdata = {1'b0, {SW{1'b0}}, new_idx};
                                        if (nodes_reg == '0)
                                        begin
                                            root_leaf_next = 1'b0;
                                        end
                                        if (level_reg == '0)
                                        begin
                                            top_node_next   = new_idx;
                                            top_second_next = 1'b0;
                                            level_next      = LW'(1);
                                        end
                                        else if (!top_second_reg)
                                        begin
                                            one_we = 1'b1;
                                            if (level_reg == LW'(STACK_DEPTH))
                                            begin
                                                bad = 1'b1;
                                            end
                                            else
                                            begin
                                                stk_we          = 1'b1;
                                                top_node_next   = new_idx;
                                                top_second_next = 1'b0;
                                                level_next      = level_reg + LW'(1);
                                            end
                                        end
                                        else
                                        begin
                                            zero_we         = 1'b1;
                                            top_node_next   = new_idx;
                                            top_second_next = 1'b0;
                                        end
                                    end
                                end
                                else if (lbt_reg != CW'(hsd_pkg::LETTER_BITS))
                                begin
                                    lbt_next    = lbt_reg + CW'(1);
                                    letter_next = letter_new;
                                end
                                else
                                begin
                                    lbt_next    = '0;
                                    letter_next = letter_new;
                                    if (nodes_reg == NCW'(NODE_SLOTS))
                                    begin
                                        bad = 1'b1;
                                    end
                                    else
                                    begin
                                        nodes_next = nodes_reg + NCW'(1);
                                        link_wdata = {1'b1, letter_new, new_idx};
                                        if (nodes_reg == '0)
                                        begin
                                            root_leaf_next   = 1'b1;
                                            root_letter_next = letter_new;
                                        end
                                        if (level_reg == '0)
                                        begin
                                            tree_done = 1'b1;
                                        end
                                        else if (!top_second_reg)
                                        begin
                                            one_we          = 1'b1;
                                            top_second_next = 1'b1;
                                        end
                                        else
                                        begin
                                            zero_we    = 1'b1;
                                            level_next = lvl_m1;
                                            if (level_reg == LW'(1))
                                            begin
                                                tree_done = 1'b1;
                                            end
                                            else
                                            begin
                                                top_node_next = below_rd_reg;
                                            end
                                        end
                                    end
                                end
                                if (tree_done)
                                begin
                                    walk_next = '0;
                                    if (rem_one)
                                    begin
                                        phase_next          = PH_DONE;
                                        rs_ctrl.push        = 1'b1;
                                        rs_ctrl.res.outcome = hsd_pkg::OC_END;
                                    end
                                    else
                                    begin
                                        phase_next = PH_DATA;
                                        prime_next = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                if (root_leaf_reg)
                                begin
                                    emit     = 1'b1;
                                    emit_sym = root_letter_reg;
                                end
                                else if (link[LINK_W-1])
                                begin
                                    emit     = 1'b1;
                                    emit_sym = link[IW+SW-1:IW];
                                end
                                else
                                begin
                                    walk_next = link[IW-1:0];
                                end
                                if (emit)
                                begin
                                    walk_next           = '0;
                                    fin_next            = rem_one;
                                    rs_ctrl.push        = 1'b1;
                                    rs_ctrl.res.symbol  = emit_sym;
                                    rs_ctrl.res.outcome = hsd_pkg::OC_SYMBOL;
                                end
                            end
                        end
                    end
                    if (bad)
                    begin
                        phase_next          = PH_DONE;
                        rs_ctrl.push        = 1'b1;
                        rs_ctrl.res.symbol  = '0;
                        rs_ctrl.res.outcome = hsd_pkg::OC_CORRUPT;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (rs_room)
                begin
                    rs_ctrl.flush = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            final_reg      <= 1'b0;
            budget_reg     <= '0;
            rem_reg        <= '0;
            phase_reg      <= PH_TREE;
            lbt_reg        <= '0;
            nodes_reg      <= '0;
            level_reg      <= '0;
            top_second_reg <= 1'b0;
            root_leaf_reg  <= 1'b0;
            walk_reg       <= '0;
            prime_reg      <= 1'b0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            final_reg      <= final_next;
            rem_reg        <= rem_next;
            phase_reg      <= phase_next;
            lbt_reg        <= lbt_next;
            nodes_reg      <= nodes_next;
            level_reg      <= level_next;
            top_second_reg <= top_second_next;
            root_leaf_reg  <= root_leaf_next;
            walk_reg       <= walk_next;
            prime_reg      <= prime_next;
            fin_reg        <= fin_next;
            if (cfg_write)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        letter_reg      <= letter_next;
        top_node_reg    <= top_node_next;
        root_letter_reg <= root_letter_next;
    end

    always_ff @(posedge clk)
    begin
        if (one_we)
        begin
            one_mem[top_node_reg] <= link_wdata;
        end
        one_rd_reg <= one_mem[walk_next];
    end

    always_ff @(posedge clk)
    begin
        if (zero_we)
        begin
            zero_mem[top_node_reg] <= link_wdata;
        end
        zero_rd_reg <= zero_mem[walk_next];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr_w] <= top_node_reg;
        end
        below_rd_reg <= stk_mem[stk_addr_r];
    end

    hsd_result_stage u_result_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rs_ctrl),
        .room      (rs_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .outcome   (outcome),
        .last      (last)
    );

    // A byte is only taken once the previous one has closed completely.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!fin_reg && !prime_reg))
        else $error("pending step left over when the decoder went idle");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        rs_ctrl.push |-> rs_room)
        else $error("result pushed while the result stage had no room");

    a_push_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(rs_ctrl.push && rs_ctrl.flush))
        else $error("result push and flush in the same cycle");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg <= LW'(STACK_DEPTH)) && (nodes_reg <= NCW'(NODE_SLOTS)))
        else $error("stack level or node count beyond its capacity");

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman stream decoder testbench
// Builds random code trees, serializes them and encodes random symbols under
// a bit budget, then streams the bytes into the decoder. A scoreboard decodes
// every accepted byte on its own and checks each output transfer in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NODE_SLOTS    = hsd_pkg::NODE_SLOTS_DEF;
    localparam int STACK_DEPTH   = hsd_pkg::STACK_DEPTH_DEF;
    localparam int SYM_W         = hsd_pkg::SYM_W;
    localparam int OUTCOME_W     = hsd_pkg::OUTCOME_W;
    localparam int BUDGET_W      = hsd_pkg::BUDGET_W;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {PH_TREE, PH_DATA, PH_DONE} walk_phase_e;
    typedef enum {STEP_MORE, STEP_DONE, STEP_BAD} tree_step_e;

    typedef struct {
        logic [SYM_W-1:0]     symbol;
        logic [OUTCOME_W-1:0] outcome;
        logic                 last;
    } decoded_t;

    class huffman_scoreboard;
        decoded_t              decoded_queue[$];
        int                    errors;
        int                    checked;
        logic [BUDGET_W-1:0]   budget;
        bit                    node_leaf [NODE_SLOTS];
        bit [7:0]              node_letter [NODE_SLOTS];
        bit [9:0]              node_one [NODE_SLOTS];
        bit [9:0]              node_zero [NODE_SLOTS];
        bit [9:0]              stack_node [STACK_DEPTH];
        bit                    stack_second [STACK_DEPTH];
        int                    level;
        int                    used;
        walk_phase_e           phase;
        int                    walk;
        bit [7:0]              letter_acc;
        int                    letter_taken;
        logic [BUDGET_W:0]     remaining;

        function new();
            budget = '0;
            restart();
        endfunction

        function void restart();
            level = 0;
            used = 0;
            phase = PH_TREE;
            walk = 0;
            letter_acc = '0;
            letter_taken = 0;
            remaining = {1'b0, budget};
        endfunction

        function void set_budget(logic [BUDGET_W-1:0] value);
            budget = value;
        endfunction

        function int pending();
            return decoded_queue.size();
        endfunction

        function void emit(logic [SYM_W-1:0] sym, logic [OUTCOME_W-1:0] oc);
            decoded_t d;
            d.symbol = sym;
            d.outcome = oc;
            d.last = 1'b0;
            decoded_queue.push_back(d);
        endfunction

        function void attach(int n);
            int top;
            if (level == 0 || level > STACK_DEPTH)
                return;
            top = level - 1;
            if (!stack_second[top])
            begin
                node_one[stack_node[top]] = 10'(n);
                stack_second[top] = 1'b1;
            end
            else
            begin
                node_zero[stack_node[top]] = 10'(n);
                level--;
            end
        endfunction

        function tree_step_e tree_bit(bit b);
            int n;
            if (letter_taken == 0)
            begin
                if (!b)
                begin
                    letter_taken = 1;
                    letter_acc = '0;
                    return STEP_MORE;
                end
                if (used >= NODE_SLOTS)
                    return STEP_BAD;
                n = used;
                used++;
                node_leaf[n] = 1'b0;
                node_letter[n] = '0;
                attach(n);
                if (level >= STACK_DEPTH)
                    return STEP_BAD;
                stack_node[level] = 10'(n);
                stack_second[level] = 1'b0;
                level++;
                return STEP_MORE;
            end
            letter_acc = {letter_acc[6:0], b};
            letter_taken++;
            if (letter_taken < 9)
                return STEP_MORE;
            letter_taken = 0;
            if (used >= NODE_SLOTS)
                return STEP_BAD;
            n = used;
            used++;
            node_leaf[n] = 1'b1;
            node_letter[n] = letter_acc;
            attach(n);
            return (level == 0) ? STEP_DONE : STEP_MORE;
        endfunction

        function void decode_byte(bit [7:0] data, bit first_b, bit final_b);
            int         mark;
            int         nxt;
            bit         b;
            tree_step_e r;
            mark = decoded_queue.size();
            if (first_b)
                restart();
            for (int i = 7; i >= 0 && phase != PH_DONE; i--)
            begin
                b = data[i];
                if (remaining == 0)
                begin
                    emit('0, hsd_pkg::OC_CORRUPT);
                    phase = PH_DONE;
                    break;
                end
                remaining = remaining - 1;
                if (phase == PH_TREE)
                begin
                    r = tree_bit(b);
                    if (r == STEP_BAD)
                    begin
                        emit('0, hsd_pkg::OC_CORRUPT);
                        phase = PH_DONE;
                    end
                    else if (r == STEP_DONE)
                    begin
                        walk = 0;
                        phase = PH_DATA;
                        if (remaining == 0)
                        begin
                            emit('0, hsd_pkg::OC_END);
                            phase = PH_DONE;
                        end
                    end
                end
                else
                begin
                    if (node_leaf[0])
                        nxt = 0;
                    else
                    begin
                        nxt = b ? int'(node_one[walk]) : int'(node_zero[walk]);
                        if (nxt >= NODE_SLOTS)
                            nxt = 0;
                    end
                    if (node_leaf[nxt])
                    begin
                        emit(node_letter[nxt], hsd_pkg::OC_SYMBOL);
                        walk = 0;
                        if (remaining == 0)
                        begin
                            emit('0, hsd_pkg::OC_END);
                            phase = PH_DONE;
                        end
                    end
                    else
                        walk = nxt;
                end
            end
            if (final_b && phase != PH_DONE)
            begin
                emit('0, hsd_pkg::OC_CORRUPT);
                phase = PH_DONE;
            end
            if (decoded_queue.size() > mark)
                decoded_queue[decoded_queue.size() - 1].last = 1'b1;
        endfunction

        function void compare_output(logic [SYM_W-1:0] sym, logic [OUTCOME_W-1:0] oc,
                                     logic lst);
            decoded_t want;
            checked++;
            if (decoded_queue.size() == 0)
            begin
                $error("output transfer with no result expected: symbol %0h outcome %0d last %0b",
                       sym, oc, lst);
                errors++;
                return;
            end
            want = decoded_queue.pop_front();
            if (sym !== want.symbol)
            begin
                $error("symbol mismatch: expected %0h, actual %0h", want.symbol, sym);
                errors++;
            end
            if (oc !== want.outcome)
            begin
                $error("outcome mismatch: expected %0d, actual %0d", want.outcome, oc);
                errors++;
            end
            if (lst !== want.last)
            begin
                $error("last mismatch: expected %0b, actual %0b", want.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [BUDGET_W-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            stream_byte;
    logic                  first;
    logic                  final_req;
    logic                  out_valid;
    logic                  out_ready;
    logic [SYM_W-1:0]      symbol;
    logic [OUTCOME_W-1:0]  outcome;
    logic                  last;

    huffman_scoreboard sb;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int stream_bytes;
    int bytes_sent;
    int frame_count;
    int budget_writes;
    int letter_mode;
    bit auto_phase;

    bit        frame_bits[$];
    bit [63:0] leaf_code[$];
    int        leaf_len[$];

    huffman_stream_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .first       (first),
        .final_req   (final_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol      (symbol),
        .outcome     (outcome),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("huffman_stream_decoder_unit verification failed");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            sb.compare_output(symbol, outcome, last);
    end

    function automatic void pick_phase();
        case ((stream_bytes / 100) % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 66;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 66;
            end
            default:
            begin
                send_idle_pct = 28;
                recv_stall_pct = 28;
            end
        endcase
    endfunction

    function automatic void grow_tree(int leaves, bit [63:0] path, int depth);
        int       ones;
        bit [7:0] letter;
        if (leaves == 1)
        begin
            if (letter_mode != 0)
                letter = (leaf_len.size() % 2) ? 8'hFF : 8'h00;
            else
                letter = 8'($urandom);
            frame_bits.push_back(1'b0);
            for (int j = 7; j >= 0; j--)
                frame_bits.push_back(letter[j]);
            leaf_code.push_back(path);
            leaf_len.push_back(depth);
        end
        else
        begin
            frame_bits.push_back(1'b1);
            ones = $urandom_range(1, leaves - 1);
            grow_tree(ones, {path[62:0], 1'b1}, depth + 1);
            grow_tree(leaves - ones, {path[62:0], 1'b0}, depth + 1);
        end
    endfunction

    function automatic void compose(int leaves, int nsym);
        int pick;
        frame_bits.delete();
        leaf_code.delete();
        leaf_len.delete();
        grow_tree(leaves, 64'd0, 0);
        repeat (nsym)
        begin
            pick = $urandom_range(0, leaf_len.size() - 1);
            if (leaf_len[pick] == 0)
                frame_bits.push_back(1'($urandom_range(0, 1)));
            else
                for (int j = leaf_len[pick] - 1; j >= 0; j--)
                    frame_bits.push_back(leaf_code[pick][j]);
        end
    endfunction

    task automatic push_byte(bit [7:0] data, bit first_b, bit final_b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= data;
        first <= first_b;
        final_req <= final_b;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.decode_byte(data, first_b, final_b);
        bytes_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(logic [BUDGET_W-1:0] value);
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_budget(value);
        budget_writes++;
    endtask

    task automatic play_frame(logic [BUDGET_W-1:0] budget_value, bit write_cfg, int cut,
                              bit final_last, int tail, int hold);
        int       nbytes;
        bit [7:0] data;
        while (frame_bits.size() % 8 != 0)
            frame_bits.push_back(1'($urandom_range(0, 1)));
        nbytes = frame_bits.size() / 8 - cut;
        if (nbytes < 1)
            nbytes = 1;
        if (write_cfg)
        begin
            settle();
            write_budget(budget_value);
        end
        hold_left = hold;
        for (int k = 0; k < nbytes; k++)
        begin
            if (auto_phase)
                pick_phase();
            for (int j = 0; j < 8; j++)
                data[7 - j] = frame_bits[8 * k + j];
            push_byte(data, k == 0, final_last && k == nbytes - 1);
            stream_bytes++;
        end
        repeat (tail) push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
        frame_count++;
    endtask

    task automatic random_frame();
        int                  leaves;
        int                  nsym;
        int                  sel;
        int                  cut;
        int                  tail;
        int                  nb;
        longint              total;
        logic [BUDGET_W-1:0] bv;
        bit                  wr;
        bit                  fin;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            leaves = 1;
        else if (sel < 8)
            leaves = $urandom_range(2, 8);
        else
            leaves = $urandom_range(9, 40);
        nsym = $urandom_range(0, 30);
        compose(leaves, nsym);
        total = frame_bits.size();
        sel = $urandom_range(0, 19);
        if (sel < 12)
            bv = total[BUDGET_W-1:0];
        else if (sel < 15)
            bv = BUDGET_W'(total - $urandom_range(1, (total < 12) ? total : 12));
        else if (sel < 17)
            bv = BUDGET_W'(total + $urandom_range(1, 20));
        else if (sel == 17)
            bv = '1;
        else if (sel == 18)
            bv = {8'($urandom), $urandom};
        else
            bv = '0;
        wr = ($urandom_range(0, 9) != 0);
        nb = int'((total + 7) / 8);
        cut = ($urandom_range(0, 9) == 0 && nb > 1) ? $urandom_range(1, nb - 1) : 0;
        fin = ($urandom_range(0, 4) != 0);
        tail = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        play_frame(bv, wr, cut, fin, tail, 0);
    endtask

    initial
    begin
        int frame_no;
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        stream_byte = '0;
        first = 1'b0;
        final_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        letter_mode = 0;
        auto_phase = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Bytes before any start of stream see a zero budget; the next one is ignored.
        push_byte(8'hA5, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b1);
        settle();
        write_budget('0);
        push_byte(8'hFF, 1'b1, 1'b0);

        letter_mode = 1;
        compose(1, 15);
        play_frame(BUDGET_W'(frame_bits.size()), 1'b1, 0, 1'b1, 1, 0);
        compose(2, 4);
        play_frame('1, 1'b1, 0, 1'b1, 0, 0);
        letter_mode = 0;
        compose(3, 0);
        play_frame(BUDGET_W'(frame_bits.size()), 1'b1, 0, 1'b1, 0, 0);
        compose(4, 4);
        play_frame(BUDGET_W'(frame_bits.size() - 3), 1'b1, 0, 1'b1, 0, 0);
        compose(2, 3);
        play_frame(BUDGET_W'(frame_bits.size() + 20), 1'b1, 0, 1'b0, 0, 0);
        compose(2, 4);
        play_frame(BUDGET_W'(frame_bits.size()), 1'b0, 0, 1'b1, 0, 0);

        stream_bytes = 0;
        frame_no = 0;
        auto_phase = 1'b1;
        while (stream_bytes < 410)
        begin
            if (frame_no == 2)
            begin
                frame_bits.delete();
                repeat (STACK_DEPTH + 1) frame_bits.push_back(1'b1);
                play_frame('1, 1'b1, 0, 1'b1, 0, 0);
            end
            else if (frame_no == 4)
            begin
                compose(1, 230);
                play_frame(BUDGET_W'(frame_bits.size()), 1'b1, 0, 1'b1, 0, 600);
            end
            else if (frame_no == 7)
            begin
                frame_bits.delete();
                repeat (STACK_DEPTH - 1) frame_bits.push_back(1'b1);
                repeat ((NODE_SLOTS - STACK_DEPTH) / 2)
                begin
                    frame_bits.push_back(1'b0);
                    repeat (8) frame_bits.push_back(1'($urandom_range(0, 1)));
                    frame_bits.push_back(1'b1);
                end
                repeat (2) frame_bits.push_back(1'b1);
                play_frame(BUDGET_W'(frame_bits.size()), 1'b1, 0, 1'b1, 0, 0);
            end
            else
                random_frame();
            frame_no++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d streams, %0d bytes in all and %0d checked output transfers.",
                 frame_count, bytes_sent, sb.checked);
        $display("It wrote the budget %0d times and drove stack overflow and full node table.",
                 budget_writes);
        if (sb.errors == 0)
            $display("huffman_stream_decoder_unit verification clean");
        else
            $display("huffman_stream_decoder_unit verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/hsd_pkg.sv
rtl/hsd_result_stage.sv
rtl/huffman_stream_decoder_unit.sv
test/testbench.sv
